FILE: hw/rtl/acal_pkg.sv
// ----------------------------------------------------------------------------
// acal_pkg: shared types and constants of the accelerometer offset calibrator
// Item and result layouts, operation and mode codes, calibration constants.
// ----------------------------------------------------------------------------
package acal_pkg;

    localparam int AXES     = 3;
    localparam int VAL_W    = 9;
    localparam int RAW_W    = 8;
    localparam int OUT_W    = 12;
    localparam int SUM_W    = 13;
    localparam int CNT_W    = 5;
    localparam int SAMPLES  = 20;
    localparam int DIV_SHIFT = 17;
    localparam int DIV_MULT  = (2 ** DIV_SHIFT + SAMPLES - 1) / SAMPLES;

    localparam logic signed [VAL_W-1:0] Z_GRAVITY = 9'sd64;
    localparam logic signed [VAL_W-1:0] LOAD_MIN  = -9'sd128;
    localparam logic signed [VAL_W-1:0] LOAD_MAX  = 9'sd128;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_START  = 2'd1,
        OP_ERASE  = 2'd2,
        OP_LOAD   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_HAVE    = 2'd1,
        MODE_RUNNING = 2'd2
    } mode_t;

    typedef struct packed {
        opcode_t                        opcode;
        logic [AXES-1:0][VAL_W-1:0]     val;
    } item_t;

    typedef struct packed {
        logic [AXES-1:0][OUT_W-1:0]     acc;
        logic                           load_error;
        logic                           cal_done;
        logic [1:0]                     cal_mode;
    } result_t;

endpackage

FILE: hw/rtl/acal_in_stage.sv
// ----------------------------------------------------------------------------
// acal_in_stage: input register
// Hold one accepted item until the core takes it.
// ----------------------------------------------------------------------------
module acal_in_stage
    import acal_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  out_free,
    output logic  take,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    assign take     = valid_reg && out_free;
    assign in_ready = !valid_reg || take;
    assign item     = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

FILE: hw/rtl/acal_core.sv
// ----------------------------------------------------------------------------
// acal_core: calibration state and per-item datapath
// Scale or correct samples, accumulate calibration runs, erase and load offsets.
// ----------------------------------------------------------------------------
module acal_core
    import acal_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    take,
    input  item_t   item,
    output result_t result
);

    logic signed [VAL_W-1:0] off_reg  [AXES];
    logic signed [VAL_W-1:0] off_next [AXES];
    logic signed [SUM_W-1:0] sum_reg  [AXES];
    logic signed [SUM_W-1:0] sum_next [AXES];
    mode_t                   mode_reg;
    mode_t                   mode_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;

    logic signed [RAW_W-1:0] raw  [AXES];
    logic signed [VAL_W-1:0] ld   [AXES];
    logic signed [9:0]       diff [AXES];
    logic signed [SUM_W-1:0] acc_sum [AXES];
    logic signed [VAL_W-1:0] quot [AXES];
    logic [AXES-1:0]         oor;
    logic [AXES-1:0]         nz;

    function automatic logic signed [VAL_W-1:0] div_samples(logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0]   mag;
        logic [30:0]        prod;
        logic [SUM_W-1:0]   q;
        logic [SUM_W-1:0]   qs;
        mag  = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        prod = 31'(mag) * 31'(DIV_MULT);
        q    = prod[DIV_SHIFT +: SUM_W];
        qs   = s[SUM_W-1] ? (~q + 1'b1) : q;
        return $signed(qs[VAL_W-1:0]);
    endfunction

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            raw[i]     = $signed(item.val[i][RAW_W-1:0]);
            ld[i]      = $signed(item.val[i]);
            diff[i]    = 10'(raw[i]) - 10'(off_reg[i]);
            acc_sum[i] = sum_reg[i] + SUM_W'(raw[i]);
            quot[i]    = div_samples(acc_sum[i]);
            oor[i]     = (ld[i] < LOAD_MIN) || (ld[i] > LOAD_MAX);
            nz[i]      = |ld[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            off_next[i]   = off_reg[i];
            sum_next[i]   = sum_reg[i];
            result.acc[i] = '0;
        end
        mode_next         = mode_reg;
        cnt_next          = cnt_reg;
        result.cal_done   = 1'b0;
        result.load_error = 1'b0;

        case (item.opcode)
            OP_SAMPLE:
            begin
                case (mode_reg)
                    MODE_NONE:
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            result.acc[i] = OUT_W'(raw[i]) <<< 2;
                        end
                    end
                    MODE_HAVE:
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            result.acc[i] = OUT_W'(diff[i]) <<< 2;
                        end
                    end
                    default:
                    begin
                        cnt_next = cnt_reg + 1'b1;
                        for (int i = 0; i < AXES; i++)
                        begin
                            result.acc[i] = OUT_W'(raw[i]);
                            sum_next[i]   = acc_sum[i];
                        end
                        if (cnt_next >= CNT_W'(SAMPLES))
                        begin
                            off_next[0] = quot[0];
                            off_next[1] = quot[1];
                            if (!acc_sum[2][SUM_W-1] && (|acc_sum[2]))
                            begin
                                off_next[2] = quot[2] - Z_GRAVITY;
                            end
                            else
                            begin
                                off_next[2] = quot[2] + Z_GRAVITY;
                            end
                            mode_next       = MODE_HAVE;
                            result.cal_done = 1'b1;
                            cnt_next        = '0;
                            for (int i = 0; i < AXES; i++)
                            begin
                                sum_next[i] = '0;
                            end
                        end
                    end
                endcase
            end
            OP_START:
            begin
                mode_next = MODE_RUNNING;
                cnt_next  = '0;
                for (int i = 0; i < AXES; i++)
                begin
                    sum_next[i] = '0;
                end
            end
            OP_ERASE:
            begin
                mode_next = MODE_HAVE;
                cnt_next  = '0;
                for (int i = 0; i < AXES; i++)
                begin
                    sum_next[i] = '0;
                    off_next[i] = '0;
                end
            end
            default:
            begin
                cnt_next = '0;
                for (int i = 0; i < AXES; i++)
                begin
                    sum_next[i] = '0;
                    off_next[i] = ld[i];
                end
                if (|oor)
                begin
                    result.load_error = 1'b1;
                    mode_next         = MODE_NONE;
                end
                else if (!(|nz))
                begin
                    mode_next = MODE_NONE;
                end
                else
                begin
                    mode_next = MODE_HAVE;
                end
            end
        endcase

        result.cal_mode = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                off_reg[i] <= '0;
                sum_reg[i] <= '0;
            end
            mode_reg <= MODE_NONE;
            cnt_reg  <= '0;
        end
        else if (take)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                off_reg[i] <= off_next[i];
                sum_reg[i] <= sum_next[i];
            end
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

FILE: hw/rtl/acal_out_stage.sv
// ----------------------------------------------------------------------------
// acal_out_stage: result register
// Hold one result until the receiver takes it.
// ----------------------------------------------------------------------------
module acal_out_stage
    import acal_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t in_result,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result
);

    logic    valid_reg;
    result_t result_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= in_result;
        end
    end

endmodule

FILE: hw/rtl/accel_offset_calibrator.sv
// ----------------------------------------------------------------------------
// accel_offset_calibrator: 3-axis accelerometer offset calibration
// Corrects samples with per-axis offsets, runs calibration, erases and loads
// offsets.
//
// Input channel s_*: one item per sample or command; s_tuser carries the
// operation, s_tdata the three axis values. Output channel m_*: exactly one
// result per item, in order; m_tdata carries the three axis outputs, m_tuser
// the mode after the item and the done and load error flags.
// An accepted item passes the input register, then the datapath and state
// update into the result register, where its result becomes valid.
// Throughput is one item per cycle while the receiver does not stall; the
// core computes each state update combinationally (the offset division is
// a constant reciprocal multiply).
// Reset clears the offsets, sums and count and sets the mode to none; both
// registers come out of reset empty. When the receiver stalls, the result
// register holds, the input register fills and s_tready drops.
// ----------------------------------------------------------------------------
module accel_offset_calibrator
    import acal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // x_value[8:0], y_value[17:9], z_value[26:18], zero fill
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // x_out[11:0], y_out[23:12], z_out[35:24], zero fill
    output logic [3:0]  m_tuser    // cal_mode[1:0], cal_done[2], load_error[3]
);

    item_t   in_item;
    item_t   item;
    result_t core_result;
    result_t out_result;
    logic    take;
    logic    out_free;

    assign in_item.opcode = opcode_t'(s_tuser);
    assign in_item.val    = s_tdata[AXES*VAL_W-1:0];

    acal_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .out_free (out_free),
        .take     (take),
        .item     (item)
    );

    acal_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .result (core_result)
    );

    acal_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .in_result (core_result),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (out_result)
    );

    assign m_tdata = {4'b0000, out_result.acc};
    assign m_tuser = {out_result.load_error, out_result.cal_done, out_result.cal_mode};

endmodule
